// File: src/fcsa_pkg.sv
package fcsa_pkg;

    // Fixed widths of the frame bookkeeping.
    localparam int FCSA_CNT_W = 11;
    localparam int FCSA_MAC_W = 48;
    localparam int FCSA_IP_W  = 32;
    localparam int FCSA_CRC_W = 32;

    // Defaults for the top-level parameters.
    localparam int FCSA_BUFFER_BYTES = 1600;
    localparam int FCSA_QUEUE_DEPTH  = 4;

    // CRC-32, reflected form.
    localparam logic [FCSA_CRC_W-1:0] FCSA_CRC_POLY = 32'hEDB88320;
    localparam logic [FCSA_CRC_W-1:0] FCSA_CRC_INIT = 32'hFFFFFFFF;

    // Byte counter saturates here.
    localparam logic [FCSA_CNT_W-1:0] FCSA_CNT_MAX = 11'd2047;

    // Frame offsets used by the ARP snoop.
    localparam logic [FCSA_CNT_W-1:0] FCSA_IDX_ETYPE_HI = 11'd12;
    localparam logic [FCSA_CNT_W-1:0] FCSA_IDX_ETYPE_LO = 11'd13;
    localparam logic [FCSA_CNT_W-1:0] FCSA_IDX_OPER_HI  = 11'd20;
    localparam logic [FCSA_CNT_W-1:0] FCSA_IDX_OPER_LO  = 11'd21;
    localparam logic [FCSA_CNT_W-1:0] FCSA_IDX_SHA_FIRST = 11'd22;
    localparam logic [FCSA_CNT_W-1:0] FCSA_IDX_SHA_LAST  = 11'd27;
    localparam logic [FCSA_CNT_W-1:0] FCSA_IDX_SPA_FIRST = 11'd28;
    localparam logic [FCSA_CNT_W-1:0] FCSA_IDX_SPA_LAST  = 11'd31;
    localparam logic [FCSA_CNT_W-1:0] FCSA_ARP_MIN_LEN   = 11'd42;

    // Expected header byte values: EtherType 0x0806, opcode 2 (reply).
    localparam logic [7:0] FCSA_ETYPE_HI = 8'h08;
    localparam logic [7:0] FCSA_ETYPE_LO = 8'h06;
    localparam logic [7:0] FCSA_OPER_HI  = 8'h00;
    localparam logic [7:0] FCSA_OPER_LO  = 8'h02;

    // Number of appended FCS bytes.
    localparam logic [2:0] FCSA_FCS_BYTES = 3'd4;

    // One command from the front end to the back end.
    typedef struct packed {
        logic [7:0]            data;
        logic                  last;
        logic                  append;
        logic                  hit;
        logic [FCSA_MAC_W-1:0] mac;
        logic [FCSA_CRC_W-1:0] fcs;
    } t_cmd;

    // One byte of the reflected CRC-32 update.
    function automatic logic [FCSA_CRC_W-1:0] fcsa_crc_byte(
        input logic [FCSA_CRC_W-1:0] crc,
        input logic [7:0]            b
    );
        logic [FCSA_CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? FCSA_CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

// File: src/fcsa_front.sv
module fcsa_front
    import fcsa_pkg::*;
#(
    parameter int BUFFER_BYTES = FCSA_BUFFER_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_frame_last,
    input  logic [FCSA_IP_W-1:0]  i_server_ip,
    output t_cmd                  o_cmd
);

    localparam logic [FCSA_CNT_W:0] BUF_LIM = (FCSA_CNT_W + 1)'(BUFFER_BYTES);

    logic [FCSA_CRC_W-1:0] r_crc, n_crc;
    logic [FCSA_CNT_W-1:0] r_count, n_count;
    logic                  r_hdr_ok, n_hdr_ok;
    logic [FCSA_MAC_W-1:0] r_mac, n_mac;
    logic [FCSA_IP_W-1:0]  r_ip, n_ip;
    logic                  oversize;
    logic                  hit;

    // Per-byte frame tracking: CRC, count, header check and capture.
    always_comb begin
        n_crc   = fcsa_crc_byte(r_crc, i_data_byte);
        n_count = (r_count < FCSA_CNT_MAX) ? r_count + 1'b1 : FCSA_CNT_MAX;

        n_hdr_ok = r_hdr_ok;
        if ((r_count == FCSA_IDX_ETYPE_HI && i_data_byte != FCSA_ETYPE_HI) ||
            (r_count == FCSA_IDX_ETYPE_LO && i_data_byte != FCSA_ETYPE_LO) ||
            (r_count == FCSA_IDX_OPER_HI  && i_data_byte != FCSA_OPER_HI)  ||
            (r_count == FCSA_IDX_OPER_LO  && i_data_byte != FCSA_OPER_LO)) begin
            n_hdr_ok = 1'b0;
        end

        n_mac = r_mac;
        if (r_count >= FCSA_IDX_SHA_FIRST && r_count <= FCSA_IDX_SHA_LAST) begin
            n_mac = {r_mac[FCSA_MAC_W-9:0], i_data_byte};
        end

        n_ip = r_ip;
        if (r_count >= FCSA_IDX_SPA_FIRST && r_count <= FCSA_IDX_SPA_LAST) begin
            n_ip = {r_ip[FCSA_IP_W-9:0], i_data_byte};
        end
    end

    // Classification of the final byte of a frame.
    assign oversize = ({1'b0, n_count} + (FCSA_CNT_W + 1)'(4)) > BUF_LIM;
    assign hit      = i_frame_last && (n_count >= FCSA_ARP_MIN_LEN) && n_hdr_ok &&
                      (i_server_ip != '0) && (n_ip == i_server_ip);

    always_comb begin
        o_cmd.data   = i_data_byte;
        o_cmd.last   = i_frame_last;
        o_cmd.append = i_frame_last && !oversize;
        o_cmd.hit    = hit;
        o_cmd.mac    = hit ? n_mac : '0;
        o_cmd.fcs    = ~n_crc;
    end

    // Frame state advances on each accepted byte and clears after the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= FCSA_CRC_INIT;
            r_count  <= '0;
            r_hdr_ok <= 1'b1;
            r_mac    <= '0;
            r_ip     <= '0;
        end else if (i_accept) begin
            if (i_frame_last) begin
                r_crc    <= FCSA_CRC_INIT;
                r_count  <= '0;
                r_hdr_ok <= 1'b1;
                r_mac    <= '0;
                r_ip     <= '0;
            end else begin
                r_crc    <= n_crc;
                r_count  <= n_count;
                r_hdr_ok <= n_hdr_ok;
                r_mac    <= n_mac;
                r_ip     <= n_ip;
            end
        end
    end

endmodule

// File: src/fcsa_queue.sv
module fcsa_queue
    import fcsa_pkg::*;
#(
    parameter int DEPTH = FCSA_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/fcsa_back.sv
module fcsa_back
    import fcsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_fcs_flag,
    output logic                  o_out_last,
    output logic                  o_arp_hit,
    output logic [FCSA_MAC_W-1:0] o_snoop_mac
);

    logic                  r_valid;
    logic [7:0]            r_byte;
    logic                  r_fcs_flag;
    logic                  r_last;
    logic                  r_hit;
    logic [FCSA_MAC_W-1:0] r_mac;
    logic [2:0]            r_pend;
    logic [FCSA_CRC_W-1:0] r_fcs_sr;
    logic                  r_pend_hit;
    logic [FCSA_MAC_W-1:0] r_pend_mac;
    logic                  advance;
    logic                  pend_busy;

    // The output register can take a new result when empty or being taken.
    assign advance   = !r_valid || !i_out_stall;
    assign pend_busy = (r_pend != '0);
    assign o_pop     = advance && !pend_busy && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= '0;
        end else if (advance) begin
            if (pend_busy) begin
                // Emit the next FCS byte, least significant first.
                r_valid    <= 1'b1;
                r_byte     <= r_fcs_sr[7:0];
                r_fcs_flag <= 1'b1;
                r_last     <= (r_pend == 3'd1);
                r_hit      <= (r_pend == 3'd1) && r_pend_hit;
                r_mac      <= (r_pend == 3'd1) ? r_pend_mac : '0;
                r_fcs_sr   <= r_fcs_sr >> 8;
                r_pend     <= r_pend - 1'b1;
            end else if (!i_empty) begin
                // Pass a frame byte; a frame that gets an FCS defers its report.
                r_valid    <= 1'b1;
                r_byte     <= i_cmd.data;
                r_fcs_flag <= 1'b0;
                if (i_cmd.append) begin
                    r_last     <= 1'b0;
                    r_hit      <= 1'b0;
                    r_mac      <= '0;
                    r_pend     <= FCSA_FCS_BYTES;
                    r_fcs_sr   <= i_cmd.fcs;
                    r_pend_hit <= i_cmd.hit;
                    r_pend_mac <= i_cmd.mac;
                end else begin
                    r_last <= i_cmd.last;
                    r_hit  <= i_cmd.hit;
                    r_mac  <= i_cmd.mac;
                end
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_fcs_flag  = r_fcs_flag;
    assign o_out_last  = r_last;
    assign o_arp_hit   = r_hit;
    assign o_snoop_mac = r_mac;

endmodule

// File: src/frame_fcs_append_arp_snoop_core.sv
// An accepted byte goes to a queue slot, then to the output register. Throughput: one
// byte in and one result out per cycle while the queue has room and the output is not
// stalled; a frame with FCS yields its length plus four results, so back-to-back frames
// stall the input once the queue is full. The CRC update is a combinational XOR network.
// Reset: i_rst_n is synchronous, active low; it clears server_ip to zero, the frame state,
// the command queue and the output register.
module frame_fcs_append_arp_snoop_core
    import fcsa_pkg::*;
#(
    parameter int BUFFER_BYTES = FCSA_BUFFER_BYTES,
    parameter int QUEUE_DEPTH  = FCSA_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [FCSA_IP_W-1:0]  i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_frame_last,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_fcs_flag,
    output logic                  o_out_last,
    output logic                  o_arp_hit,
    output logic [FCSA_MAC_W-1:0] o_snoop_mac
);

    logic [FCSA_IP_W-1:0] r_server_ip;
    logic                 in_accept;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    t_cmd                 front_cmd;
    t_cmd                 q_cmd;

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_ip <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_server_ip <= i_cfg_data;
        end
    end

    // Input request is taken whenever the queue has room.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    fcsa_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .i_server_ip  (r_server_ip),
        .o_cmd        (front_cmd)
    );

    fcsa_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fcsa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_fcs_flag  (o_fcs_flag),
        .o_out_last  (o_out_last),
        .o_arp_hit   (o_arp_hit),
        .o_snoop_mac (o_snoop_mac)
    );

    // A hit is only reported on the final result of a frame.
    a_hit_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_arp_hit |-> o_out_last)
        else $error("arp hit reported on a result that is not final");

    // The MAC field is zero unless a hit is reported.
    a_mac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_arp_hit |-> o_snoop_mac == '0)
        else $error("snooped mac nonzero without a hit");

    // FCS bytes come as an unbroken run up to the final one.
    a_fcs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_fcs_flag && !o_out_last
        |=> o_out_valid && o_fcs_flag)
        else $error("fcs byte run broken");

endmodule
